/* rtl/hav_pkg.sv */
`timescale 1ns / 1ps
package hav_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_NAME   = 7'b0000010,
    PH_PORT   = 7'b0000100,
    PH_OPEN   = 7'b0001000,
    PH_V6     = 7'b0010000,
    PH_FUTURE = 7'b0100000,
    PH_CLOSED = 7'b1000000
  } phase_t;

  localparam logic [1:0] KIND_NAME   = 2'd0;
  localparam logic [1:0] KIND_V6     = 2'd1;
  localparam logic [1:0] KIND_FUTURE = 2'd2;

  // byte classes made at the front
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       text_empty;
    logic       dig;
    logic       hexd;
    logic       namech;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  host_kind;
    logic        ip_literal;
    logic        has_port;
    logic        port_empty;
    logic        port_valid;
    logic [15:0] port_number;
  } result_t;

  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_dig(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_name(input logic [7:0] b);
    logic r;
    r = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) || is_dig(b);
    case (b)
      8'h2d, 8'h2e, 8'h5f, 8'h7e, 8'h21, 8'h24, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h3b, 8'h3d: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

endpackage

/* rtl/hav_front.sv */
`timescale 1ns / 1ps
module hav_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    data_byte,
  input  logic          is_last,
  input  logic          text_empty,
  input  logic          push,
  output logic          full,
  output hav_pkg::item_t item,
  output logic          item_valid,
  input  logic          item_take
);
  import hav_pkg::*;

  item_t q [QueueDepth];
  logic [$clog2(QueueDepth):0] count;
  logic [$clog2(QueueDepth)-1:0] wr_ptr, rd_ptr;
  logic do_push, do_pop;
  item_t cls;

  assign full = count == ($clog2(QueueDepth)+1)'(QueueDepth);
  assign item_valid = count != '0;
  assign item = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = item_take && item_valid;

  always_comb begin
    cls.data_byte  = data_byte;
    cls.is_last    = is_last;
    cls.text_empty = text_empty;
    cls.dig        = is_dig(data_byte);
    cls.hexd       = is_hex(data_byte);
    cls.namech     = is_name(data_byte);
    cls.digit      = data_byte[3:0];
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cls;
    if (rst) begin
      count <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (($clog2(QueueDepth)+1)'(do_push))
                     - (($clog2(QueueDepth)+1)'(do_pop));
    end
  end
endmodule

/* rtl/hav_back.sv */
`timescale 1ns / 1ps
module hav_back (
  input  logic            clk,
  input  logic            rst,
  input  hav_pkg::item_t  item,
  input  logic            item_valid,
  output logic            item_take,
  output logic            empty,
  input  logic            pop,
  output hav_pkg::result_t res
);
  import hav_pkg::*;

  phase_t phase, phase_n;
  logic failed, failed_n;
  logic [1:0] kind, kind_n;
  logic [3:0] groups, groups_n;
  logic comp, comp_n;
  logic [1:0] crun, crun_n;
  logic [2:0] slen, slen_n;
  logic shex, shex_n, sdot, sdot_n;
  logic [1:0] oidx, oidx_n;
  logic [8:0] oval, oval_n;
  logic [1:0] odig, odig_n;
  logic olz, olz_n;
  logic [1:0] esc, esc_n;
  logic pseen, pseen_n, pdig, pdig_n, povf, povf_n;
  logic [15:0] pacc, pacc_n;
  logic out_full;
  result_t r;
  logic [7:0] b;
  logic last;
  logic [4:0] gsum;
  logic [12:0] v10;
  logic [19:0] p10;
  logic fin_bad;

  assign empty = !out_full;
  assign item_take = item_valid && (!out_full || pop);
  assign b = item.data_byte;
  assign last = item.text_empty || item.is_last;

  always_comb begin
    phase_n = phase; failed_n = failed; kind_n = kind; groups_n = groups;
    comp_n = comp; crun_n = crun; slen_n = slen; shex_n = shex; sdot_n = sdot;
    oidx_n = oidx; oval_n = oval; odig_n = odig; olz_n = olz; esc_n = esc;
    pseen_n = pseen; pdig_n = pdig; povf_n = povf; pacc_n = pacc;
    gsum = '0;
    v10 = 13'(oval) * 13'd10 + 13'(item.digit);
    p10 = 20'(pacc) * 20'd10 + 20'(item.digit);
    if (!item.text_empty && !failed) begin
      case (phase)
        PH_START, PH_NAME: begin
          if (phase == PH_START && b == "[") phase_n = PH_OPEN;
          else begin
            phase_n = PH_NAME;
            if (esc != 2'd0) begin
              if (item.hexd) esc_n = esc - 2'd1; else failed_n = 1'b1;
            end else if (item.namech) begin
            end else if (b == "%") esc_n = 2'd2;
            else if (b == ":") begin
              phase_n = PH_PORT; pseen_n = 1'b1;
            end else failed_n = 1'b1;
          end
        end
        PH_PORT: begin
          if (!item.dig) failed_n = 1'b1;
          else begin
            pdig_n = 1'b1;
            if (!povf) begin
              if (p10 > 20'd65535) begin
                povf_n = 1'b1; pacc_n = '0;
              end else pacc_n = p10[15:0];
            end
          end
        end
        PH_OPEN, PH_V6: begin
          if (phase == PH_OPEN && b == "]") failed_n = 1'b1;
          else if (phase == PH_OPEN && (b == "v" || b == "V")) begin
            kind_n = KIND_FUTURE; phase_n = PH_FUTURE;
          end else if (phase == PH_V6 && b == "]") begin
            // closing bracket: finish the last segment
            gsum = {1'b0, groups};
            if (crun == 2'd1 || crun == 2'd3) failed_n = 1'b1;
            else begin
              if (slen != 3'd0) begin
                if (sdot) begin
                  if (oidx != 2'd3 || odig == 2'd0) failed_n = 1'b1;
                  else gsum = {1'b0, groups} + 5'd2;
                end else if (slen > 3'd4 || !shex) failed_n = 1'b1;
                else gsum = {1'b0, groups} + 5'd1;
              end
              if (!failed_n) begin
                if (gsum > 5'd15) gsum = 5'd15;
                groups_n = gsum[3:0];
                if (comp ? (gsum >= 5'd8) : (gsum != 5'd8)) failed_n = 1'b1;
                else phase_n = PH_CLOSED;
              end
            end
          end else begin
            if (phase == PH_OPEN) begin
              kind_n = KIND_V6; phase_n = PH_V6;
            end
            if (b == ":") begin
              if (slen != 3'd0) begin
                if (sdot || slen > 3'd4 || !shex) failed_n = 1'b1;
                else begin
                  if (groups != 4'd15) groups_n = groups + 4'd1;
                  crun_n = 2'd1;
                  slen_n = '0; shex_n = 1'b1; sdot_n = 1'b0;
                  oidx_n = '0; oval_n = '0; odig_n = '0; olz_n = 1'b0;
                end
              end else if (crun == 2'd0) crun_n = 2'd3;
              else if (crun == 2'd2 || comp) failed_n = 1'b1;
              else begin
                comp_n = 1'b1; crun_n = 2'd2;
              end
            end else if (crun == 2'd3) failed_n = 1'b1;
            else begin
              crun_n = 2'd0;
              if (!sdot) begin
                if (b == ".") begin
                  if (slen < 3'd1 || slen > 3'd3 || !shex || {1'b0, odig} != slen
                      || oval > 9'd255 || (odig > 2'd1 && olz)) failed_n = 1'b1;
                  else begin
                    sdot_n = 1'b1; oidx_n = 2'd1;
                    oval_n = '0; odig_n = '0; olz_n = 1'b0;
                  end
                end else begin
                  if (!item.hexd) shex_n = 1'b0;
                  if (slen < 3'd5) slen_n = slen + 3'd1;
                  if (item.dig && odig < 2'd3) begin
                    if (odig == 2'd0) olz_n = b == "0";
                    oval_n = v10 > 13'd256 ? 9'd256 : v10[8:0];
                    odig_n = odig + 2'd1;
                  end
                end
              end else if (item.dig) begin
                if (odig == 2'd3 || (odig == 2'd1 && olz)) failed_n = 1'b1;
                else begin
                  if (odig == 2'd0) olz_n = b == "0";
                  oval_n = v10[8:0];
                  odig_n = odig + 2'd1;
                  if (v10 > 13'd255) failed_n = 1'b1;
                end
              end else if (b == ".") begin
                if (odig == 2'd0 || oidx == 2'd3) failed_n = 1'b1;
                else begin
                  oidx_n = oidx + 2'd1;
                  oval_n = '0; odig_n = '0; olz_n = 1'b0;
                end
              end else failed_n = 1'b1;
            end
          end
        end
        PH_FUTURE: begin
          if (b == "]") begin
            if (!sdot || odig == 2'd0) failed_n = 1'b1; else phase_n = PH_CLOSED;
          end else if (!sdot) begin
            if (item.hexd) slen_n = 3'd1;
            else if (b == "." && slen != 3'd0) sdot_n = 1'b1;
            else failed_n = 1'b1;
          end else if (item.namech || b == ":") odig_n = 2'd1;
          else failed_n = 1'b1;
        end
        PH_CLOSED: begin
          if (b == ":") begin
            phase_n = PH_PORT; pseen_n = 1'b1;
          end else failed_n = 1'b1;
        end
        default: failed_n = 1'b1;
      endcase
    end
    // end-of-text judgment, only feeds the result
    fin_bad = failed_n;
    if (!failed_n) begin
      if (phase_n == PH_NAME) begin
        if (esc_n != 2'd0) fin_bad = 1'b1;
      end else if (phase_n != PH_START && phase_n != PH_CLOSED && phase_n != PH_PORT)
        fin_bad = 1'b1;
    end
    r = '0;
    if (!fin_bad) begin
      r.accepted = 1'b1;
      r.host_kind = kind_n;
      r.ip_literal = kind_n != KIND_NAME;
      r.has_port = pseen_n;
      r.port_empty = pseen_n && !pdig_n;
      r.port_valid = pdig_n && !povf_n;
      r.port_number = (pdig_n && !povf_n) ? pacc_n : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && last) res <= r;
    if (rst) begin
      out_full <= 1'b0;
    end else if (item_take && last) out_full <= 1'b1;
    else if (pop) out_full <= 1'b0;
    if (rst || (item_take && last)) begin
      phase <= PH_START; failed <= 1'b0; kind <= KIND_NAME; groups <= '0;
      comp <= 1'b0; crun <= '0; slen <= '0; shex <= 1'b1; sdot <= 1'b0;
      oidx <= '0; oval <= '0; odig <= '0; olz <= 1'b0; esc <= '0;
      pseen <= 1'b0; pdig <= 1'b0; povf <= 1'b0; pacc <= '0;
    end else if (item_take) begin
      phase <= phase_n; failed <= failed_n; kind <= kind_n; groups <= groups_n;
      comp <= comp_n; crun <= crun_n; slen <= slen_n; shex <= shex_n; sdot <= sdot_n;
      oidx <= oidx_n; oval <= oval_n; odig <= odig_n; olz <= olz_n; esc <= esc_n;
      pseen <= pseen_n; pdig <= pdig_n; povf <= povf_n; pacc <= pacc_n;
    end
  end
endmodule

/* rtl/http_authority_validator.sv */
`timescale 1ns / 1ps
// Path: a result reaches the ports after its last byte has passed through the
// front queue and then the result register.
// Throughput: one byte per cycle while no result waits unpopped; the front queue
// holds two bytes, and the result register accepts a new result in the cycle the old one is popped.
// Reset (rst, synchronous): queue and result register emptied, parser state
// back to start of text.
module http_authority_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        text_empty,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic        accepted,
  output logic [1:0]  host_kind,
  output logic        ip_literal,
  output logic        has_port,
  output logic        port_empty,
  output logic        port_valid,
  output logic [15:0] port_number
);
  import hav_pkg::*;

  item_t item;
  logic item_valid, item_take;
  result_t res;

  hav_front u_front (
    .clk, .rst, .data_byte, .is_last, .text_empty, .push, .full,
    .item, .item_valid, .item_take
  );

  hav_back u_back (
    .clk, .rst, .item, .item_valid, .item_take, .empty, .pop, .res
  );

  assign accepted    = res.accepted;
  assign host_kind   = res.host_kind;
  assign ip_literal  = res.ip_literal;
  assign has_port    = res.has_port;
  assign port_empty  = res.port_empty;
  assign port_valid  = res.port_valid;
  assign port_number = res.port_number;
endmodule
